### rtl/surf_counter_mode_byte_generator_defines.svh
// Assertion macros for the SURF byte generator checker.
// Every macro samples on i_clk; the two guarded forms are off while i_rst_n is low.
`ifndef SURF_COUNTER_MODE_BYTE_GENERATOR_DEFINES_SVH
`define SURF_COUNTER_MODE_BYTE_GENERATOR_DEFINES_SVH

// Consequence checked in the same cycle as the condition.
`define SCMBG_ASSERT_SAME(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("scmbg: property failed");

// Consequence checked in the cycle after the condition.
`define SCMBG_ASSERT_NEXT(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("scmbg: property failed");

// Consequence checked in the cycle after reset is seen low.
`define SCMBG_ASSERT_RESET(lbl, expr) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (expr)) \
        else $error("scmbg: reset property failed");

`endif

### rtl/scmbg_pkg.sv
// Shared types, constants and helper functions of the SURF byte generator.
// Used by the core modules, the top level and the testbench; depends on nothing.
package scmbg_pkg;

    localparam int WORD_W      = 32;
    localparam int SEED_DEPTH  = 32;
    localparam int SEED_AW     = 5;
    localparam int WORK_WORDS  = 12;
    localparam int BLOCK_WORDS = 8;
    localparam int CTR_WORDS   = 4;
    localparam int CTR_W       = CTR_WORDS * WORD_W;
    localparam int COUNT_W     = 7;
    localparam int LEFT_W      = 6;
    localparam int STEP_W      = 4;
    localparam int INIT_W      = 5;

    localparam logic [COUNT_W-1:0] MAX_REQUEST_BYTES = 7'd64;
    localparam logic [LEFT_W-1:0]  BLOCK_BYTES       = 6'd32;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP    = 32'h9e3779b9;
    localparam logic [SEED_AW-1:0] SEED_WORK_BASE = 5'd12;
    localparam logic [INIT_W-1:0]  INIT_LAST      = 5'd20;
    localparam logic [STEP_W-1:0]  STEP_LAST      = 4'd11;
    localparam logic [STEP_W-1:0]  ROUND_LAST     = 4'd15;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic               en;
        logic [SEED_AW-1:0] addr;
        t_word              data;
    } t_seed_wr;

    typedef enum logic [1:0] {
        T_IDLE,
        T_EMIT,
        T_SURF
    } t_top_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MUSH,
        S_FOLD,
        S_DONE
    } t_surf_state;

    // Left rotation by the MUSH amount chosen by the low two bits of the word index.
    function automatic t_word mush_rotl(input t_word v, input logic [1:0] sel);
        t_word r;
        case (sel)
            2'd0:    r = {v[WORD_W-6:0],  v[WORD_W-1:WORD_W-5]};
            2'd1:    r = {v[WORD_W-8:0],  v[WORD_W-1:WORD_W-7]};
            2'd2:    r = {v[WORD_W-10:0], v[WORD_W-1:WORD_W-9]};
            default: r = {v[WORD_W-14:0], v[WORD_W-1:WORD_W-13]};
        endcase
        return r;
    endfunction

endpackage

### rtl/scmbg_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing but plain logic types.
interface scmbg_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [4:0]  seed_index;
    logic [31:0] seed_word;
    logic [6:0]  byte_count;

    modport source (output valid, output opcode, output seed_index, output seed_word,
                    output byte_count, input ready);
    modport sink   (input valid, input opcode, input seed_index, input seed_word,
                    input byte_count, output ready);
endinterface

interface scmbg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] random_byte;
    logic       last_byte;

    modport source (output valid, output random_byte, output last_byte, input ready);
    modport sink   (input valid, input random_byte, input last_byte, output ready);
endinterface

### rtl/scmbg_mush.sv
// Single MUSH update: mixes the chaining word, one seed word and the round sum
// into one work word. Depends on scmbg_pkg.
module scmbg_mush (
    input  scmbg_pkg::t_word i_chain,
    input  scmbg_pkg::t_word i_seed,
    input  scmbg_pkg::t_word i_work,
    input  scmbg_pkg::t_word i_sum,
    input  logic [1:0]       i_rot_sel,
    output scmbg_pkg::t_word o_word
);

    scmbg_pkg::t_word s_mix;

    always_comb begin
        s_mix  = ((i_chain ^ i_seed) + i_sum) ^ scmbg_pkg::mush_rotl(i_chain, i_rot_sel);
        o_word = i_work + s_mix;
    end

endmodule

### rtl/scmbg_surf.sv
// SURF sequencer: seed memory, twelve work words in a rotating line, the output
// block and the step counters that drive one shared MUSH unit. Depends on
// scmbg_pkg and scmbg_mush.
module scmbg_surf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scmbg_pkg::t_seed_wr               i_wr,
    input  logic                              i_start,
    input  logic [scmbg_pkg::CTR_W-1:0]       i_ctr,
    output logic                              o_done,
    output scmbg_pkg::t_word                  o_block [scmbg_pkg::BLOCK_WORDS]
);

    scmbg_pkg::t_surf_state r_state, n_state;

    scmbg_pkg::t_word r_seed_mem [scmbg_pkg::SEED_DEPTH];
    scmbg_pkg::t_word r_seed_q;
    scmbg_pkg::t_word r_work [scmbg_pkg::WORK_WORDS];
    scmbg_pkg::t_word r_blk  [scmbg_pkg::BLOCK_WORDS];
    scmbg_pkg::t_word r_sum;

    logic [scmbg_pkg::INIT_W-1:0] r_cnt;
    logic [scmbg_pkg::STEP_W-1:0] r_k;
    logic [scmbg_pkg::STEP_W-1:0] r_rnd;
    logic                         r_pass;

    logic [scmbg_pkg::SEED_AW-1:0] s_rd_addr;
    logic [scmbg_pkg::INIT_W-1:0]  s_init_i;
    scmbg_pkg::t_word              s_ctr_word;
    scmbg_pkg::t_word              s_mush;

    scmbg_mush u_mush (
        .i_chain   (r_work[scmbg_pkg::WORK_WORDS-1]),
        .i_seed    (r_seed_q),
        .i_work    (r_work[0]),
        .i_sum     (r_sum),
        .i_rot_sel (r_k[1:0]),
        .o_word    (s_mush)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            scmbg_pkg::S_IDLE: begin
                if (i_start) n_state = scmbg_pkg::S_INIT;
            end
            scmbg_pkg::S_INIT: begin
                if (r_cnt == scmbg_pkg::INIT_LAST) n_state = scmbg_pkg::S_MUSH;
            end
            scmbg_pkg::S_MUSH: begin
                if (r_k == scmbg_pkg::STEP_LAST && r_rnd == scmbg_pkg::ROUND_LAST) begin
                    n_state = scmbg_pkg::S_FOLD;
                end
            end
            scmbg_pkg::S_FOLD: begin
                n_state = r_pass ? scmbg_pkg::S_DONE : scmbg_pkg::S_MUSH;
            end
            scmbg_pkg::S_DONE: n_state = scmbg_pkg::S_IDLE;
            default:           n_state = scmbg_pkg::S_IDLE;
        endcase
    end

    // Outputs: the seed read address is issued in the cycle before its use.
    always_comb begin
        s_rd_addr = '0;
        o_done    = 1'b0;
        case (r_state)
            scmbg_pkg::S_IDLE: s_rd_addr = scmbg_pkg::SEED_WORK_BASE;
            scmbg_pkg::S_INIT: begin
                if (r_cnt != scmbg_pkg::INIT_LAST) begin
                    s_rd_addr = scmbg_pkg::SEED_WORK_BASE + r_cnt;
                end
            end
            scmbg_pkg::S_MUSH: begin
                if (r_k != scmbg_pkg::STEP_LAST) s_rd_addr = {1'b0, r_k + 4'd1};
            end
            scmbg_pkg::S_DONE: o_done = 1'b1;
            default:           s_rd_addr = '0;
        endcase
    end

    always_comb begin
        s_init_i   = r_cnt - 5'd1;
        s_ctr_word = (s_init_i < 5'(scmbg_pkg::CTR_WORDS)) ?
                     i_ctr[s_init_i[1:0]*scmbg_pkg::WORD_W +: scmbg_pkg::WORD_W] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) r_seed_mem[i_wr.addr] <= i_wr.data;
        r_seed_q <= r_seed_mem[s_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scmbg_pkg::S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_rnd   <= '0;
            r_pass  <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                scmbg_pkg::S_IDLE: begin
                    r_cnt <= '0;
                end
                scmbg_pkg::S_INIT: begin
                    r_cnt <= r_cnt + 5'd1;
                    r_k   <= '0;
                    r_rnd <= '0;
                    r_pass <= 1'b0;
                    r_sum <= scmbg_pkg::GOLDEN_STEP;
                end
                scmbg_pkg::S_MUSH: begin
                    if (r_k == scmbg_pkg::STEP_LAST) begin
                        r_k   <= '0;
                        r_sum <= r_sum + scmbg_pkg::GOLDEN_STEP;
                        r_rnd <= (r_rnd == scmbg_pkg::ROUND_LAST) ? '0 : r_rnd + 4'd1;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                scmbg_pkg::S_FOLD: begin
                    r_pass <= 1'b1;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    // Work words and output block shift in at the tail during load-up; during
    // MUSH the head is updated and rotated to the tail, which is the chaining word.
    always_ff @(posedge i_clk) begin
        case (r_state)
            scmbg_pkg::S_INIT: begin
                if (r_cnt != '0) begin
                    if (s_init_i < 5'(scmbg_pkg::WORK_WORDS)) begin
                        for (int j = 0; j < scmbg_pkg::WORK_WORDS - 1; j++) begin
                            r_work[j] <= r_work[j+1];
                        end
                        r_work[scmbg_pkg::WORK_WORDS-1] <= s_ctr_word ^ r_seed_q;
                    end else begin
                        for (int j = 0; j < scmbg_pkg::BLOCK_WORDS - 1; j++) begin
                            r_blk[j] <= r_blk[j+1];
                        end
                        r_blk[scmbg_pkg::BLOCK_WORDS-1] <= r_seed_q;
                    end
                end
            end
            scmbg_pkg::S_MUSH: begin
                for (int j = 0; j < scmbg_pkg::WORK_WORDS - 1; j++) begin
                    r_work[j] <= r_work[j+1];
                end
                r_work[scmbg_pkg::WORK_WORDS-1] <= s_mush;
            end
            scmbg_pkg::S_FOLD: begin
                for (int j = 0; j < scmbg_pkg::BLOCK_WORDS; j++) begin
                    r_blk[j] <= r_blk[j] ^ r_work[j+4];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int j = 0; j < scmbg_pkg::BLOCK_WORDS; j++) o_block[j] = r_blk[j];
    end

endmodule

### rtl/surf_counter_mode_byte_generator.sv
// Top level of the SURF keyed counter-mode byte generator.
// Depends on scmbg_pkg, scmbg_if and scmbg_surf.
//
// Request channel i_in: a load item (opcode 0) writes seed_word into seed word
// seed_index and is done in the cycle it is taken. A generate item (opcode 1)
// asks for byte_count bytes (above 64 is treated as 64, zero gives nothing).
// While a generate is being served i_in.ready stays low.
// Result channel o_out: one item per byte, last_byte set on the final byte of a
// request. A single output register sits between the block and the receiver.
// With bytes left in the block, an accepted request first moves the sequencer
// to its emit state, which then loads the first byte into the output register.
// Throughput: bytes of the current 32-byte block go out at one per cycle while
// the receiver does not stall. When the block runs out, the 128-bit counter is
// incremented and SURF is run: the start, the seed reads, 384 MUSH updates
// through the one shared MUSH unit at one per cycle, two folds and a done
// state.
// Reset clears the counter, the bytes-left count and the output valid flag; seed
// words must be loaded before the first generate. When the receiver stalls the
// byte in the output register holds and the block waits.
module surf_counter_mode_byte_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scmbg_in_if.sink    i_in,
    scmbg_out_if.source o_out
);

    scmbg_pkg::t_top_state r_state, n_state;

    logic [scmbg_pkg::CTR_W-1:0]   r_ctr;
    logic [scmbg_pkg::LEFT_W-1:0]  r_bytes_left;
    logic [scmbg_pkg::COUNT_W-1:0] r_remain;
    logic                          r_ovalid;
    logic [7:0]                    r_obyte;
    logic                          r_olast;

    logic                          s_accept;
    logic                          s_gen;
    logic [scmbg_pkg::COUNT_W-1:0] s_count;
    logic                          s_out_free;
    logic                          s_start;
    logic                          s_emit;
    logic [4:0]                    s_idx;
    scmbg_pkg::t_word              s_word;
    scmbg_pkg::t_seed_wr           s_wr;
    logic                          s_done;
    scmbg_pkg::t_word              s_block [scmbg_pkg::BLOCK_WORDS];

    scmbg_surf u_surf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (s_wr),
        .i_start (s_start),
        .i_ctr   (r_ctr),
        .o_done  (s_done),
        .o_block (s_block)
    );

    assign i_in.ready = (r_state == scmbg_pkg::T_IDLE);
    assign s_accept   = i_in.valid && i_in.ready;
    assign s_gen      = s_accept && (i_in.opcode == scmbg_pkg::OP_GEN);
    assign s_count    = (i_in.byte_count > scmbg_pkg::MAX_REQUEST_BYTES) ?
                        scmbg_pkg::MAX_REQUEST_BYTES : i_in.byte_count;
    assign s_out_free = !r_ovalid || o_out.ready;

    assign s_wr.en   = s_accept && (i_in.opcode == scmbg_pkg::OP_LOAD);
    assign s_wr.addr = i_in.seed_index;
    assign s_wr.data = i_in.seed_word;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            scmbg_pkg::T_IDLE: begin
                if (s_gen && s_count != '0) n_state = scmbg_pkg::T_EMIT;
            end
            scmbg_pkg::T_EMIT: begin
                if (s_out_free) begin
                    if (r_bytes_left == '0) n_state = scmbg_pkg::T_SURF;
                    else if (r_remain == 7'd1) n_state = scmbg_pkg::T_IDLE;
                end
            end
            scmbg_pkg::T_SURF: begin
                if (s_done) n_state = scmbg_pkg::T_EMIT;
            end
            default: n_state = scmbg_pkg::T_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_start = 1'b0;
        s_emit  = 1'b0;
        case (r_state)
            scmbg_pkg::T_EMIT: begin
                s_start = s_out_free && (r_bytes_left == '0);
                s_emit  = s_out_free && (r_bytes_left != '0);
            end
            default: begin
                s_start = 1'b0;
                s_emit  = 1'b0;
            end
        endcase
    end

    // Block bytes run from 31 down to 0; byte k is byte k mod 4 of word k/4.
    always_comb begin
        s_idx  = 5'(r_bytes_left - 6'd1);
        s_word = s_block[s_idx[4:2]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= scmbg_pkg::T_IDLE;
            r_ctr        <= '0;
            r_bytes_left <= '0;
            r_remain     <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_gen) r_remain <= s_count;
            if (s_start) r_ctr <= r_ctr + 128'd1;
            if (r_state == scmbg_pkg::T_SURF && s_done) r_bytes_left <= scmbg_pkg::BLOCK_BYTES;
            if (s_emit) begin
                r_bytes_left <= r_bytes_left - 6'd1;
                r_remain     <= r_remain - 7'd1;
                r_ovalid     <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_obyte <= s_word[{s_idx[1:0], 3'b000} +: 8];
            r_olast <= (r_remain == 7'd1);
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.random_byte = r_obyte;
    assign o_out.last_byte   = r_olast;

endmodule

### rtl/scmbg_checker.sv
// Port-level checks for the SURF byte generator, bound to the top level.
// Depends on the assertion macros in the defines header.
`include "surf_counter_mode_byte_generator_defines.svh"

module scmbg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // A waiting result item is neither dropped nor changed.
    `SCMBG_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `SCMBG_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready,
                       $stable(i_out_byte) && $stable(i_out_last))

    // A request still has bytes to go after a byte that is not its last.
    `SCMBG_ASSERT_SAME(a_busy_mid_request, i_out_valid && !i_out_last, !i_in_ready)

    `SCMBG_ASSERT_RESET(a_reset_empty, !i_out_valid)

endmodule

bind surf_counter_mode_byte_generator scmbg_checker u_scmbg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.random_byte),
    .i_out_last  (o_out.last_byte)
);

### tb/tb.sv
// Self-checking testbench for the SURF counter-mode byte generator.
// Depends on scmbg_pkg, the scmbg_if channel interfaces and the top level;
// a local SURF predictor checks every byte and its last marker.
`timescale 1ns / 100ps

module tb;
    import scmbg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          QUIET_TAIL  = 16;
    localparam int          HOLD_CYCLES = 600;
    localparam int          HOLD_AFTER  = 400;
    localparam int          RANDOM_REQS = 66;

    typedef struct {
        logic        op;
        logic [4:0]  idx;
        logic [31:0] word;
        logic [6:0]  cnt;
    } req_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } gen_byte_t;

    logic i_clk;
    logic i_rst_n;

    scmbg_in_if  in_ch ();
    scmbg_out_if out_ch ();

    surf_counter_mode_byte_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state.
    t_word        seed_mem [SEED_DEPTH];
    logic [127:0] blk_ctr;
    t_word        out_block [BLOCK_WORDS];
    t_word        work [WORK_WORDS];
    t_word        chain;
    t_word        gsum;
    int           bytes_avail;

    req_t        pending_reqs [$];
    gen_byte_t   expected_bytes [$];

    int unsigned cycles;
    int          total_reqs;
    int          n_accepted;
    int          n_loads;
    int          n_gens;
    int          n_bytes;
    int          n_blocks;
    int          errors;
    logic        item_taken;
    int          send_gap;
    int          recv_gap;
    int          hold_left;
    logic        hold_done;

    function automatic t_word rotl_word(input t_word v, input int s);
        return (v << s) | (v >> (WORD_W - s));
    endfunction

    // One SURF evaluation keyed by the seed words, on the current counter.
    function automatic void surf_block();
        int rots [4];
        t_word mix;
        rots = '{5, 7, 9, 13};
        for (int k = 0; k < WORK_WORDS; k++) begin
            work[k] = (k < CTR_WORDS ? blk_ctr[32*k +: 32] : 32'd0) ^ seed_mem[12 + k];
        end
        for (int k = 0; k < BLOCK_WORDS; k++) begin
            out_block[k] = seed_mem[24 + k];
        end
        chain = work[WORK_WORDS-1];
        gsum  = '0;
        for (int p = 0; p < 2; p++) begin
            for (int r = 0; r < 16; r++) begin
                gsum = gsum + GOLDEN_STEP;
                for (int k = 0; k < WORK_WORDS; k++) begin
                    mix = ((chain ^ seed_mem[k]) + gsum) ^ rotl_word(chain, rots[k & 3]);
                    work[k] = work[k] + mix;
                    chain = work[k];
                end
            end
            for (int k = 0; k < BLOCK_WORDS; k++) begin
                out_block[k] = out_block[k] ^ work[k + 4];
            end
        end
    endfunction

    task automatic predict_request(input logic op, input logic [4:0] idx,
                                   input logic [31:0] word, input logic [6:0] cnt);
        int        want;
        int        k;
        gen_byte_t b;
        if (op == OP_LOAD) begin
            seed_mem[idx] = word;
            n_loads++;
        end else begin
            n_gens++;
            want = (cnt > MAX_REQUEST_BYTES) ? int'(MAX_REQUEST_BYTES) : int'(cnt);
            for (int n = 0; n < want; n++) begin
                if (bytes_avail == 0) begin
                    blk_ctr = blk_ctr + 128'd1;
                    surf_block();
                    n_blocks++;
                    bytes_avail = 32;
                end
                bytes_avail--;
                k = bytes_avail;
                b.value = out_block[k >> 2][8*(k & 3) +: 8];
                b.last  = (n + 1 == want);
                expected_bytes.push_back(b);
            end
        end
    endtask

    function automatic req_t mk_load(input logic [4:0] idx, input logic [31:0] word);
        req_t r;
        r.op   = OP_LOAD;
        r.idx  = idx;
        r.word = word;
        r.cnt  = 7'($urandom);
        return r;
    endfunction

    function automatic req_t mk_gen(input logic [6:0] cnt);
        req_t r;
        r.op   = OP_GEN;
        r.idx  = 5'($urandom);
        r.word = $urandom;
        r.cnt  = cnt;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Request driver: presents queued items at the falling edge, with idle bursts.
    always @(negedge i_clk) begin
        req_t nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !item_taken) begin
            // Item still on offer; hold it.
        end else if (send_gap != 0) begin
            send_gap--;
            in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
            in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 13);
            in_ch.valid <= 1'b0;
        end else begin
            nxt = pending_reqs.pop_front();
            in_ch.valid      <= 1'b1;
            in_ch.opcode     <= nxt.op;
            in_ch.seed_index <= nxt.idx;
            in_ch.seed_word  <= nxt.word;
            in_ch.byte_count <= nxt.cnt;
        end
        item_taken = 1'b0;
    end

    // Result receiver: random stall bursts plus one long hold-off that backs
    // the block up so that its request channel stalls.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (!hold_done && n_bytes >= HOLD_AFTER
                     && pending_reqs.size() >= QUIET_TAIL) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ch.ready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            out_ch.ready <= 1'b0;
        end else if (pending_reqs.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 13);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Monitor: predicts on every accepted request and checks every accepted byte.
    always @(posedge i_clk) begin
        gen_byte_t exp_b;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycles, expected_bytes.size());
            $display("surf_counter_mode_byte_generator test failed");
            $finish;
        end else if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                predict_request(in_ch.opcode, in_ch.seed_index, in_ch.seed_word,
                                in_ch.byte_count);
                n_accepted++;
                item_taken = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected byte %02h last %b at cycle %0d",
                                 out_ch.random_byte, out_ch.last_byte, cycles);
                end else begin
                    exp_b = expected_bytes.pop_front();
                    n_bytes++;
                    if (out_ch.random_byte !== exp_b.value
                        || out_ch.last_byte !== exp_b.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("byte %0d: expected %02h last %b, got %02h last %b",
                                     n_bytes, exp_b.value, exp_b.last,
                                     out_ch.random_byte, out_ch.last_byte);
                    end
                end
            end
        end
    end

    initial begin
        int r;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_LOAD;
        in_ch.seed_index = '0;
        in_ch.seed_word  = '0;
        in_ch.byte_count = '0;
        out_ch.ready     = 1'b0;
        cycles      = 0;
        n_accepted  = 0;
        n_loads     = 0;
        n_gens      = 0;
        n_bytes     = 0;
        n_blocks    = 0;
        errors      = 0;
        item_taken  = 1'b0;
        send_gap    = 0;
        recv_gap    = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        blk_ctr     = '0;
        bytes_avail = 0;
        chain       = '0;
        gsum        = '0;
        for (int k = 0; k < SEED_DEPTH; k++) seed_mem[k] = '0;

        // Key every seed word before any generate, extremes at both ends.
        for (int k = 0; k < SEED_DEPTH; k++) begin
            if (k == 0)
                pending_reqs.push_back(mk_load(5'(k), 32'h0000_0000));
            else if (k == SEED_DEPTH - 1 || k == 12)
                pending_reqs.push_back(mk_load(5'(k), 32'hffff_ffff));
            else
                pending_reqs.push_back(mk_load(5'(k), $urandom));
        end

        // Directed requests: single byte, block boundaries, zero count,
        // saturation above the limit and a reload in the middle of a block.
        pending_reqs.push_back(mk_gen(7'd1));
        pending_reqs.push_back(mk_gen(7'd31));
        pending_reqs.push_back(mk_gen(7'd0));
        pending_reqs.push_back(mk_gen(7'd32));
        pending_reqs.push_back(mk_gen(7'd64));
        pending_reqs.push_back(mk_gen(7'd65));
        pending_reqs.push_back(mk_gen(7'd127));
        pending_reqs.push_back(mk_gen(7'd3));
        pending_reqs.push_back(mk_load(5'd31, 32'h0000_0000));
        pending_reqs.push_back(mk_load(5'd0, 32'hffff_ffff));
        pending_reqs.push_back(mk_gen(7'd40));
        pending_reqs.push_back(mk_gen(7'd100));

        // Random traffic, mostly generates of modest size with loads mixed in.
        for (int i = 0; i < RANDOM_REQS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                pending_reqs.push_back(mk_load(5'($urandom), $urandom));
            else if (r < 25)
                pending_reqs.push_back(mk_gen(7'd0));
            else if (r < 30)
                pending_reqs.push_back(mk_gen(7'd64));
            else if (r < 37)
                pending_reqs.push_back(mk_gen(7'($urandom_range(65, 127))));
            else if (r < 75)
                pending_reqs.push_back(mk_gen(7'($urandom_range(1, 16))));
            else
                pending_reqs.push_back(mk_gen(7'($urandom_range(17, 63))));
        end
        total_reqs = pending_reqs.size();

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (n_accepted == total_reqs);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d loads and %0d generates, %0d bytes checked from %0d blocks",
                 n_loads, n_gens, n_bytes, n_blocks);
        $display("long receiver hold-off exercised: %0d, mismatches: %0d", hold_done, errors);
        if (errors == 0) begin
            $display("surf_counter_mode_byte_generator test passed");
        end else begin
            $display("surf_counter_mode_byte_generator test failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/scmbg_pkg.sv
rtl/scmbg_if.sv
rtl/scmbg_mush.sv
rtl/scmbg_surf.sv
rtl/surf_counter_mode_byte_generator.sv
rtl/scmbg_checker.sv
tb/tb.sv
